[hw/rtl/rmts_pkg.sv]
package rmts_pkg;

	localparam int TASK_SLOTS = 3;
	localparam int CFG_SLOTS  = 3;

	localparam int TIME_W     = 32;
	localparam int PERIOD_W   = 16;
	localparam int COUNT_W    = 2;
	localparam int TASK_NUM_W = 2;
	localparam int SLOT_W     = $clog2(TASK_SLOTS + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT   = 3'd0;
	localparam int                   REG_PERIOD_BASE  = 1;
	localparam int                   REG_BUDGET_BASE  = REG_PERIOD_BASE + CFG_SLOTS;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 3'd7;

	// remainder unit: bits of the tick time consumed per cycle
	localparam int STEP_BITS = 4;
	localparam int DIV_STEPS = TIME_W / STEP_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [COUNT_W-1:0]                 task_count;
		logic [TASK_SLOTS-1:0][PERIOD_W-1:0] period;
		logic [TASK_SLOTS-1:0][PERIOD_W-1:0] budget;
		logic [TIME_W-1:0]                  frame_length;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic div_step;
		logic reload;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

[hw/rtl/rmts_cfg.sv]
module rmts_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [rmts_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [rmts_pkg::CFG_DATA_W-1:0]    wr_data,
	output rmts_pkg::cfg_t                     cfg
);
	import rmts_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.task_count <= '0;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				cfg_q.period[i] <= PERIOD_W'(1);
				cfg_q.budget[i] <= '0;
			end
			cfg_q.frame_length <= TIME_W'(1);
		end else if (wr_en) begin
			if (wr_index == REG_TASK_COUNT) begin
				cfg_q.task_count <= wr_data[COUNT_W-1:0];
			end
			if (wr_index == REG_FRAME_LENGTH) begin
				cfg_q.frame_length <= wr_data[TIME_W-1:0];
			end
			for (int s = 0; s < CFG_SLOTS; s++) begin
				if (s < TASK_SLOTS) begin
					if (int'(wr_index) == REG_PERIOD_BASE + s) begin
						cfg_q.period[s] <= wr_data[PERIOD_W-1:0];
					end
					if (int'(wr_index) == REG_BUDGET_BASE + s) begin
						cfg_q.budget[s] <= wr_data[PERIOD_W-1:0];
					end
				end
			end
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/rmts_ctrl.sv]
module rmts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rmts_pkg::dp_stat_t   stat,
	output rmts_pkg::dp_cmd_t    cmd
);
	import rmts_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_REL  = 2'd2;
	localparam logic [1:0] ST_SEL  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = ST_REL;
				end
			end
			ST_REL: begin
				cmd.reload = 1'b1;
				state_d    = ST_SEL;
			end
			ST_SEL: begin
				// hold until the output register can take the word
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

[hw/rtl/rmts_dp.sv]
module rmts_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rmts_pkg::cfg_t                      cfg,
	input  rmts_pkg::dp_cmd_t                   cmd,
	output rmts_pkg::dp_stat_t                  stat,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rmts_pkg::TIME_W-1:0]         tick_time,
	output logic                                running,
	output logic [rmts_pkg::TASK_NUM_W-1:0]     task_number
);
	import rmts_pkg::*;

	function automatic logic [PERIOD_W-1:0] rem_step(
		input logic [PERIOD_W-1:0]  r,
		input logic [STEP_BITS-1:0] bits,
		input logic [PERIOD_W-1:0]  p
	);
		logic [PERIOD_W:0]   acc;
		logic [PERIOD_W-1:0] cur;
		cur = r;
		for (int k = STEP_BITS - 1; k >= 0; k--) begin
			acc = {cur, bits[k]};
			if (acc >= {1'b0, p}) begin
				acc = acc - {1'b0, p};
			end
			cur = acc[PERIOD_W-1:0];
		end
		return cur;
	endfunction

	logic [TIME_W-1:0]                   time_q;
	logic [TIME_W-1:0]                   tick_q;
	logic [TIME_W-1:0]                   div_q;
	logic [DIV_CNT_W-1:0]                cnt_q;
	logic [TASK_SLOTS-1:0][PERIOD_W-1:0] rem_q;
	logic [TASK_SLOTS-1:0][PERIOD_W-1:0] budget_q;

	logic                                out_valid_q;
	logic [TIME_W-1:0]                   tick_time_q;
	logic                                running_q;
	logic [TASK_NUM_W-1:0]               task_number_q;

	logic [TASK_SLOTS-1:0]               in_use;
	logic                                found;
	logic [SLOT_W-1:0]                   sel_idx;
	logic [PERIOD_W-1:0]                 best_p;
	logic [SLOT_W:0]                     sel_num;
	logic                                wrap;

	always_comb begin
		for (int i = 0; i < TASK_SLOTS; i++) begin
			in_use[i] = (i < int'(cfg.task_count));
		end
	end

	// shortest period among slots with budget left, lowest slot wins a tie
	always_comb begin
		found   = 1'b0;
		sel_idx = '0;
		best_p  = '0;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			if (in_use[i] && budget_q[i] != '0 && (!found || cfg.period[i] < best_p)) begin
				found   = 1'b1;
				sel_idx = SLOT_W'(i);
				best_p  = cfg.period[i];
			end
		end
		sel_num = {1'b0, sel_idx} + (SLOT_W + 1)'(1);
	end

	// frame length of zero behaves as one
	assign wrap = (cfg.frame_length == '0) || (tick_q >= cfg.frame_length - TIME_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			tick_q <= restart ? '0 : time_q;
			div_q  <= restart ? '0 : time_q;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			div_q <= div_q << STEP_BITS;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				rem_q[i] <= rem_step(rem_q[i], div_q[TIME_W-1 -: STEP_BITS], cfg.period[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			budget_q <= '0;
		end else begin
			if (cmd.start && restart) begin
				budget_q <= '0;
			end
			if (cmd.reload) begin
				for (int i = 0; i < TASK_SLOTS; i++) begin
					if (in_use[i] && cfg.period[i] != '0 && rem_q[i] == '0) begin
						budget_q[i] <= cfg.budget[i];
					end
				end
			end
			if (cmd.commit) begin
				for (int i = 0; i < TASK_SLOTS; i++) begin
					if (found && sel_idx == SLOT_W'(i)) begin
						budget_q[i] <= budget_q[i] - PERIOD_W'(1);
					end
				end
				time_q <= wrap ? '0 : tick_q + TIME_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			tick_time_q   <= tick_q;
			running_q     <= found;
			task_number_q <= found ? sel_num[TASK_NUM_W-1:0] : '0;
		end
	end

	assign stat.div_done = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign tick_time   = tick_time_q;
	assign running     = running_q;
	assign task_number = task_number_q;

endmodule

[hw/rtl/rate_monotonic_tick_scheduler.sv]
// channel   direction  handshake            word
// in        input      in_valid / in_stall  restart
// out       output     out_valid / out_stall tick_time, running, task_number
// cfg       input      wr_en                wr_index, wr_data
//
// a tick steps through accept, the remainder unit (4 bits of the tick time per
// cycle, one lane per slot), release, then select and commit.
// the next tick is accepted while the previous word still waits at the output.
// a stalled output holds the block in its select step until the register frees.
// reset clears time, budgets and all handshake state and sets the configuration to its defaults.
module rate_monotonic_tick_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rmts_pkg::TIME_W-1:0]         tick_time,
	output logic                                running,
	output logic [rmts_pkg::TASK_NUM_W-1:0]     task_number,
	input  logic                                wr_en,
	input  logic [rmts_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [rmts_pkg::CFG_DATA_W-1:0]     wr_data
);
	import rmts_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	rmts_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	rmts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rmts_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.stat        (stat),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tick_time   (tick_time),
		.running     (running),
		.task_number (task_number)
	);

endmodule

[hw/rtl/rmts_checker.sv]
module rmts_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [rmts_pkg::TIME_W-1:0]         tick_time,
	input logic                                running,
	input logic [rmts_pkg::TASK_NUM_W-1:0]     task_number
);
	import rmts_pkg::*;

	// a held word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tick_time) &&
		$stable(running) && $stable(task_number))
		else $error("output word changed while stalled");

	// a tick in flight blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a word was taken");

	// a new word only appears at the end of a tick's work
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output word without a tick in progress");

	// idle ticks carry no task number
	a_idle_number: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (running == (task_number != '0)))
		else $error("running flag and task number disagree");

endmodule

bind rate_monotonic_tick_scheduler rmts_checker u_rmts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.tick_time   (tick_time),
	.running     (running),
	.task_number (task_number)
);

[test/tb_rate_monotonic_tick_scheduler.sv]
module tb_rate_monotonic_tick_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	import rmts_pkg::*;

	typedef struct {
		logic [TIME_W-1:0]     tick_time;
		logic                  running;
		logic [TASK_NUM_W-1:0] task_number;
	} tick_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  restart = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [TIME_W-1:0]     tick_time;
	logic                  running;
	logic [TASK_NUM_W-1:0] task_number;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	// scheduler copy: registers, tick time and budget left per slot
	cfg_t              sched_cfg;
	logic [TIME_W-1:0]   now_time;
	logic [PERIOD_W-1:0] budget_left [TASK_SLOTS];

	tick_word_t expected_ticks [$];
	int         mismatches = 0;
	logic       quiet = 1'b0;

	rate_monotonic_tick_scheduler u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tick_time   (tick_time),
		.running     (running),
		.task_number (task_number),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic tick_word_t schedule_tick(input logic rs);
		tick_word_t        w;
		int                sel;
		logic [TIME_W-1:0] frame;
		sel = -1;
		if (rs) begin
			now_time = '0;
			foreach (budget_left[i]) budget_left[i] = '0;
		end
		// release slots in use whose period divides the tick time
		for (int i = 0; i < sched_cfg.task_count; i++) begin
			if (sched_cfg.period[i] != 0) begin
				if (now_time % sched_cfg.period[i] == 0)
					budget_left[i] = sched_cfg.budget[i];
			end
		end
		// shortest period wins, lowest slot on a tie; period zero ranks first
		for (int i = 0; i < sched_cfg.task_count; i++) begin
			if (budget_left[i] != 0) begin
				if (sel < 0)
					sel = i;
				else if (sched_cfg.period[i] < sched_cfg.period[sel])
					sel = i;
			end
		end
		w.tick_time = now_time;
		if (sel >= 0) begin
			budget_left[sel] = budget_left[sel] - 1'b1;
			w.running = 1'b1;
			w.task_number = TASK_NUM_W'(sel + 1);
		end else begin
			w.running = 1'b0;
			w.task_number = '0;
		end
		frame = (sched_cfg.frame_length == 0) ? TIME_W'(1) : sched_cfg.frame_length;
		now_time = (now_time >= frame - 1'b1) ? '0 : now_time + 1'b1;
		return w;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		mismatches++;
		$display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// output side: random stall, checked against the oldest expected word
	always @(negedge clk) begin
		out_stall = !quiet && ($urandom_range(99) < 13);
	end

	always @(posedge clk) begin
		tick_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ticks.size() == 0) begin
				report("word with nothing expected, tick_time", tick_time, -1);
			end else begin
				want = expected_ticks.pop_front();
				if (tick_time !== want.tick_time)
					report("tick_time", tick_time, want.tick_time);
				if (running !== want.running)
					report("running", running, want.running);
				if (task_number !== want.task_number)
					report("task_number", task_number, want.task_number);
			end
		end
	end

	// called at a falling edge, returns at one with the word still driven
	task automatic send_tick(input logic rs);
		if (!quiet && $urandom_range(99) < 13) begin
			in_valid = 1'b0;
			restart = 1'($urandom_range(1));
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid = 1'b1;
		restart = rs;
		do @(posedge clk); while (in_stall);
		expected_ticks.push_back(schedule_tick(rs));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (expected_ticks.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		if (idx == REG_TASK_COUNT)
			sched_cfg.task_count = data[COUNT_W-1:0];
		else if (idx == REG_FRAME_LENGTH)
			sched_cfg.frame_length = data;
		else if (idx < REG_BUDGET_BASE)
			sched_cfg.period[idx - REG_PERIOD_BASE] = data[PERIOD_W-1:0];
		else
			sched_cfg.budget[idx - REG_BUDGET_BASE] = data[PERIOD_W-1:0];
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// writes every register, unused upper data bits random
	task automatic configure(input logic [COUNT_W-1:0] cnt,
			input logic [PERIOD_W-1:0] p0, input logic [PERIOD_W-1:0] p1,
			input logic [PERIOD_W-1:0] p2, input logic [PERIOD_W-1:0] b0,
			input logic [PERIOD_W-1:0] b1, input logic [PERIOD_W-1:0] b2,
			input logic [TIME_W-1:0] frame);
		logic [CFG_DATA_W-1:0] d;
		logic [PERIOD_W-1:0]   per [TASK_SLOTS];
		logic [PERIOD_W-1:0]   bud [TASK_SLOTS];
		per = '{p0, p1, p2};
		bud = '{b0, b1, b2};
		d = $urandom;
		d[COUNT_W-1:0] = cnt;
		write_reg(REG_TASK_COUNT, d);
		for (int s = 0; s < TASK_SLOTS; s++) begin
			d = $urandom;
			d[PERIOD_W-1:0] = per[s];
			write_reg(CFG_IDX_W'(REG_PERIOD_BASE + s), d);
			d = $urandom;
			d[PERIOD_W-1:0] = bud[s];
			write_reg(CFG_IDX_W'(REG_BUDGET_BASE + s), d);
		end
		write_reg(REG_FRAME_LENGTH, frame);
	endtask

	function automatic logic [PERIOD_W-1:0] pick_period();
		int r;
		r = $urandom_range(99);
		if (r < 6) return '0;
		if (r < 12) return '1;
		if (r < 20) return PERIOD_W'($urandom_range(65535));
		return PERIOD_W'($urandom_range(1, 8));
	endfunction

	function automatic logic [PERIOD_W-1:0] pick_budget();
		int r;
		r = $urandom_range(99);
		if (r < 6) return '1;
		if (r < 12) return PERIOD_W'($urandom_range(65535));
		return PERIOD_W'($urandom_range(0, 4));
	endfunction

	function automatic logic [TIME_W-1:0] pick_frame();
		int r;
		r = $urandom_range(99);
		if (r < 8) return '0;
		if (r < 14) return '1;
		if (r < 20) return $urandom;
		return $urandom_range(1, 40);
	endfunction

	task automatic test_after_reset();
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		drain();
	endtask

	task automatic test_rate_order();
		configure(3, 4, 6, 12, 1, 2, 3, 12);
		repeat (5) send_tick(1'b0);
		send_tick(1'b1);
		drain();
	endtask

	task automatic test_tie_break();
		configure(3, 5, 5, 5, 1, 1, 1, 5);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		drain();
	endtask

	task automatic test_period_zero();
		configure(1, 7, 1, 1, 4, 1, 0, 100);
		send_tick(1'b1);
		drain();
		// slot zero keeps its budget and now outranks slot one
		configure(2, 0, 1, 1, 4, 1, 0, 100);
		repeat (4) send_tick(1'b0);
		drain();
	endtask

	task automatic test_frame_zero();
		configure(1, 1, 1, 1, 1, 0, 0, 0);
		send_tick(1'b0);
		send_tick(1'b0);
		drain();
	endtask

	task automatic test_unused_slots();
		configure(3, 9, 9, 9, 1, 0, 2, 50);
		send_tick(1'b1);
		drain();
		configure(1, 9, 9, 9, 1, 0, 2, 50);
		send_tick(1'b0);
		drain();
		// slot two still holds budget from before
		configure(3, 9, 9, 9, 1, 0, 2, 50);
		send_tick(1'b0);
		drain();
		// restart clears slot two even while it is out of use
		configure(1, 9, 9, 9, 1, 0, 2, 50);
		send_tick(1'b1);
		drain();
		configure(3, 9, 9, 9, 1, 0, 2, 50);
		send_tick(1'b0);
		drain();
	endtask

	task automatic test_extremes();
		configure(3, '1, '1, '1, '1, '1, '1, '1);
		send_tick(1'b1);
		send_tick(1'b0);
		drain();
		configure(0, 1, 1, 1, 0, 0, 0, 1);
		send_tick(1'b0);
		drain();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 0)
				configure(3, '1, '1, '1, '1, '1, '1, '1);
			else if (ph == 1)
				configure(0, 1, 1, 1, 0, 0, 0, 1);
			else
				configure(COUNT_W'($urandom_range(3)), pick_period(), pick_period(),
					pick_period(), pick_budget(), pick_budget(), pick_budget(),
					pick_frame());
			// one long stretch with no idling on either side
			quiet = (ph == 4);
			repeat (55) send_tick($urandom_range(99) < 5);
			drain();
		end
		quiet = 1'b0;
	endtask

	initial begin
		sched_cfg.task_count = '0;
		for (int s = 0; s < TASK_SLOTS; s++) begin
			sched_cfg.period[s] = PERIOD_W'(1);
			sched_cfg.budget[s] = '0;
			budget_left[s] = '0;
		end
		sched_cfg.frame_length = TIME_W'(1);
		now_time = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_after_reset();
		test_rate_order();
		test_tie_break();
		test_period_zero();
		test_frame_zero();
		test_unused_slots();
		test_extremes();
		test_random();

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
